// ===== sv/tsd_pkg.sv =====
// ----------------------------------------------------------------------------
// Tar stream deframer package
// Shared constants, result codes and the phase type of the tar deframer.
// ----------------------------------------------------------------------------
package tsd_pkg;

  localparam int BLOCK_BYTES = 512;
  localparam int SIZE_DIGITS = 12;
  localparam int OFFSET_W    = $clog2(BLOCK_BYTES);
  localparam int SIZE_W      = 36;
  localparam int BYTE_W      = 8;

  localparam logic [OFFSET_W-1:0] SIZE_OFFSET = OFFSET_W'(124);
  localparam logic [OFFSET_W-1:0] SIZE_END    = OFFSET_W'(124 + SIZE_DIGITS);
  localparam logic [OFFSET_W-1:0] TYPE_OFFSET = OFFSET_W'(156);
  localparam logic [OFFSET_W-1:0] LAST_OFFSET = OFFSET_W'(BLOCK_BYTES - 1);

  localparam logic [BYTE_W-1:0] CHAR_ZERO    = 8'h30;
  localparam logic [BYTE_W-1:0] CHAR_SEVEN   = 8'h37;
  localparam logic [BYTE_W-1:0] CHAR_SPACE   = 8'h20;
  localparam logic [BYTE_W-1:0] TYPE_REGULAR = 8'h30;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_HEADER  = 1'b1;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_DATA   = 2'd1,
    PH_PAD    = 2'd2
  } phase_t;

endpackage

// ===== sv/tar_stream_deframer_unit.sv =====
// ----------------------------------------------------------------------------
// Tar stream deframer
// Cuts a byte stream into 512-byte tar blocks, reports regular file headers
// with their size and passes regular file payload through without padding.
// ----------------------------------------------------------------------------
// The archive enters one byte per transfer on the input channel (in_valid,
// in_ready, data_byte). Each byte updates the block position and header
// decode state in the cycle it is accepted, and any result it causes sits
// in the output register from the next cycle on (out_valid, out_ready).
// A result is either a header result (result_kind = 1, file_bytes holds the
// decoded octal size) or a payload byte (result_kind = 0, last_of_file marks
// the final byte of the file). Header bytes, padding and the data of other
// entry types produce no result.
// Each result leaves through the output register. Throughput is one
// byte per cycle, limited only by the single output register: a new byte is
// taken whenever that register is empty or is being drained in the same
// cycle. When the receiver stalls with a result pending, in_ready drops.
// Reset clears the decode state to the start of a header block and empties
// the output register; the block is ready in the first cycle after reset.
// ----------------------------------------------------------------------------
module tar_stream_deframer_unit
  import tsd_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [BYTE_W-1:0] data_byte,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              result_kind,
  output logic [BYTE_W-1:0] payload_byte,
  output logic              last_of_file,
  output logic [SIZE_W-1:0] file_bytes
);

  phase_t              phase, phase_next;
  logic [OFFSET_W-1:0] block_offset, block_offset_next;
  logic [SIZE_W-1:0]   size_accumulator, size_accumulator_next;
  logic                digit_seen, digit_seen_next;
  logic                digits_ended, digits_ended_next;
  logic [BYTE_W-1:0]   entry_type, entry_type_next;
  logic [SIZE_W-1:0]   bytes_remaining, bytes_remaining_next;
  logic                discarding_data, discarding_data_next;

  logic                step;
  logic [OFFSET_W-1:0] offset_inc;
  logic [SIZE_W-1:0]   remaining_dec;
  logic                in_size_field;
  logic                is_digit;
  logic                is_regular;
  logic                at_block_end;

  logic                emit;
  logic                emit_kind;
  logic                emit_last;
  logic [SIZE_W-1:0]   emit_bytes;

  assign in_ready      = !out_valid || out_ready;
  assign step          = in_valid && in_ready;
  assign offset_inc    = block_offset + OFFSET_W'(1);
  assign remaining_dec = bytes_remaining - SIZE_W'(1);
  assign in_size_field = (block_offset >= SIZE_OFFSET) && (block_offset < SIZE_END)
                         && !digits_ended;
  assign is_digit      = (data_byte inside {[CHAR_ZERO:CHAR_SEVEN]});
  assign is_regular    = (entry_type == TYPE_REGULAR);
  assign at_block_end  = (block_offset == LAST_OFFSET);

  always_comb begin
    phase_next = phase;
    case (phase)
      PH_DATA: begin
        if (remaining_dec == '0) begin
          phase_next = (offset_inc == '0) ? PH_HEADER : PH_PAD;
        end
      end
      PH_PAD: begin
        if (offset_inc == '0) begin
          phase_next = PH_HEADER;
        end
      end
      default: begin
        if (at_block_end && digit_seen && (size_accumulator != '0)) begin
          phase_next = PH_DATA;
        end else begin
          phase_next = PH_HEADER;
        end
      end
    endcase
  end

  always_comb begin
    block_offset_next     = offset_inc;
    size_accumulator_next = size_accumulator;
    digit_seen_next       = digit_seen;
    digits_ended_next     = digits_ended;
    entry_type_next       = entry_type;
    bytes_remaining_next  = bytes_remaining;
    discarding_data_next  = discarding_data;
    case (phase)
      PH_DATA: begin
        bytes_remaining_next = remaining_dec;
      end
      PH_PAD: begin
      end
      default: begin
        if (in_size_field) begin
          if (is_digit) begin
            size_accumulator_next = {size_accumulator[SIZE_W-4:0], data_byte[2:0]};
            digit_seen_next       = 1'b1;
          end else if (!(data_byte == CHAR_SPACE && !digit_seen)) begin
            digits_ended_next = 1'b1;
          end
        end
        if (block_offset == TYPE_OFFSET) begin
          entry_type_next = data_byte;
        end
        if (at_block_end) begin
          bytes_remaining_next  = digit_seen ? size_accumulator : '0;
          discarding_data_next  = !is_regular;
          size_accumulator_next = '0;
          digit_seen_next       = 1'b0;
          digits_ended_next     = 1'b0;
          entry_type_next       = '0;
        end
      end
    endcase
  end

  always_comb begin
    emit       = 1'b0;
    emit_kind  = KIND_PAYLOAD;
    emit_last  = 1'b0;
    emit_bytes = '0;
    case (phase)
      PH_DATA: begin
        emit      = !discarding_data;
        emit_last = (remaining_dec == '0);
      end
      PH_PAD: begin
      end
      default: begin
        if (at_block_end && is_regular && digit_seen) begin
          emit       = 1'b1;
          emit_kind  = KIND_HEADER;
          emit_bytes = size_accumulator;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_HEADER;
      block_offset     <= '0;
      size_accumulator <= '0;
      digit_seen       <= 1'b0;
      digits_ended     <= 1'b0;
      entry_type       <= '0;
      bytes_remaining  <= '0;
      discarding_data  <= 1'b0;
    end else if (step) begin
      phase            <= phase_next;
      block_offset     <= block_offset_next;
      size_accumulator <= size_accumulator_next;
      digit_seen       <= digit_seen_next;
      digits_ended     <= digits_ended_next;
      entry_type       <= entry_type_next;
      bytes_remaining  <= bytes_remaining_next;
      discarding_data  <= discarding_data_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= step && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (step && emit) begin
      result_kind  <= emit_kind;
      payload_byte <= (emit_kind == KIND_PAYLOAD) ? data_byte : '0;
      last_of_file <= emit_last;
      file_bytes   <= emit_bytes;
    end
  end

endmodule
